FILE: design/count_repeated_values_unit_defines.svh
// Assertion macros shared by the repeated-value counter.
`ifndef COUNT_REPEATED_VALUES_UNIT_DEFINES_SVH
`define COUNT_REPEATED_VALUES_UNIT_DEFINES_SVH

// Checked at every rising edge outside reset.
`define CRV_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Checked at every rising edge, reset included.
`define CRV_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: design/crv_pkg.sv
// Shared constants, state encoding and control structs of the repeated-value counter.
package crv_pkg;

	localparam int CAPACITY = 64;
	localparam int ADDR_W   = $clog2(CAPACITY);
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int VAL_W    = 32;
	localparam int RES_W    = 6;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_KEY_RD,
		ST_KEY_LD,
		ST_CMP_RD,
		ST_CMP_EV,
		ST_TALLY,
		ST_REPORT
	} state_t;

	typedef struct packed {
		logic load;
		logic scan_init;
		logic rd_key;
		logic key_ld;
		logic cmp;
		logic tally;
		logic finish;
	} cmd_t;

	typedef struct packed {
		logic empty;
		logic j_end;
		logic i_end;
	} sts_t;

endpackage

FILE: design/crv_datapath.sv
// Value store, scan counters, comparator and result registers.
module crv_datapath import crv_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  cmd_t                    cmd,
	input  logic signed [VAL_W-1:0] value,
	output sts_t                    sts,
	output logic [RES_W-1:0]        repeated_count,
	output logic                    overflow
);

	logic [VAL_W-1:0]  mem [CAPACITY];
	logic [VAL_W-1:0]  rdata_q;
	logic [VAL_W-1:0]  key_q;
	logic [CNT_W-1:0]  count_q;
	logic              ovf_q;
	logic [ADDR_W-1:0] i_q;
	logic [ADDR_W-1:0] j_q;
	logic              seen_q;
	logic              multi_q;
	logic [RES_W-1:0]  total_q;
	logic              full;
	logic              hit;
	logic [ADDR_W-1:0] rd_addr;

	assign full    = (count_q == CNT_W'(CAPACITY));
	assign hit     = (rdata_q == key_q);
	assign rd_addr = cmd.rd_key ? i_q : j_q;

	always_ff @(posedge clk) begin
		if (cmd.load && !full) begin
			mem[count_q[ADDR_W-1:0]] <= value;
		end
		rdata_q <= mem[rd_addr];
		if (cmd.key_ld) begin
			key_q <= rdata_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			ovf_q   <= 1'b0;
			i_q     <= '0;
			j_q     <= '0;
			seen_q  <= 1'b0;
			multi_q <= 1'b0;
			total_q <= '0;
		end else begin
			if (cmd.load) begin
				if (full) begin
					ovf_q <= 1'b1;
				end else begin
					count_q <= count_q + CNT_W'(1);
				end
			end
			if (cmd.scan_init) begin
				i_q     <= ADDR_W'(1);
				total_q <= '0;
			end
			if (cmd.key_ld) begin
				j_q     <= '0;
				seen_q  <= 1'b0;
				multi_q <= 1'b0;
			end
			if (cmd.cmp) begin
				if (hit) begin
					seen_q  <= 1'b1;
					multi_q <= seen_q;
				end
				j_q <= j_q + ADDR_W'(1);
			end
			// count an index whose value occurred exactly once before it
			if (cmd.tally) begin
				if (seen_q && !multi_q && (total_q != '1)) begin
					total_q <= total_q + RES_W'(1);
				end
				i_q <= i_q + ADDR_W'(1);
			end
			if (cmd.finish) begin
				count_q <= '0;
				ovf_q   <= 1'b0;
			end
		end
	end

	assign sts.empty = (count_q == '0);
	assign sts.j_end = ((j_q + ADDR_W'(1)) == i_q);
	assign sts.i_end = ((CNT_W'(i_q) + CNT_W'(1)) == count_q);

	assign repeated_count = total_q;
	assign overflow       = ovf_q;

endmodule

FILE: design/crv_ctrl.sv
// Sequencer for loading the set and walking the pairwise scan.
module crv_ctrl import crv_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  logic last,
	input  sts_t sts,
	output cmd_t cmd,
	output logic busy,
	output logic done
);

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		busy    = 1'b1;
		done    = 1'b0;
		case (state_q)
			ST_IDLE: begin
				busy = 1'b0;
				if (start) begin
					cmd.load = 1'b1;
					if (last) begin
						cmd.scan_init = 1'b1;
						state_d = sts.empty ? ST_REPORT : ST_KEY_RD;
					end
				end
			end
			ST_KEY_RD: begin
				cmd.rd_key = 1'b1;
				state_d = ST_KEY_LD;
			end
			ST_KEY_LD: begin
				cmd.key_ld = 1'b1;
				state_d = ST_CMP_RD;
			end
			ST_CMP_RD: begin
				state_d = ST_CMP_EV;
			end
			ST_CMP_EV: begin
				cmd.cmp = 1'b1;
				state_d = sts.j_end ? ST_TALLY : ST_CMP_RD;
			end
			ST_TALLY: begin
				cmd.tally = 1'b1;
				state_d = sts.i_end ? ST_REPORT : ST_KEY_RD;
			end
			ST_REPORT: begin
				done       = 1'b1;
				cmd.finish = 1'b1;
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

FILE: design/count_repeated_values_unit.sv
// Top level of the repeated-value counter: sequencer plus datapath.
//
//  channel   handshake          payload
//  input     start / busy       value[31:0] signed, last
//  result    done (strobe)      repeated_count[5:0], overflow
//
// A value without last is taken while idle; busy stays low between loads.
// The result strobe follows the transfer of the last item after the
// pairwise scan over the one read port of the value store, which reads
// one stored value per compare.
// Reset clears the held count and the overflow flag; the store needs no clearing.
// The receiver cannot stall: done is high for exactly one cycle.
`include "count_repeated_values_unit_defines.svh"

module count_repeated_values_unit import crv_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	output logic                    busy,
	input  logic signed [VAL_W-1:0] value,
	input  logic                    last,
	output logic                    done,
	output logic [RES_W-1:0]        repeated_count,
	output logic                    overflow
);

	cmd_t cmd;
	sts_t sts;

	crv_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.last   (last),
		.sts    (sts),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	crv_datapath u_datapath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.value          (value),
		.sts            (sts),
		.repeated_count (repeated_count),
		.overflow       (overflow)
	);

	`CRV_ASSERT(a_done_busy, done |-> busy, "result strobe outside the busy window")
	`CRV_ASSERT(a_done_idle, done |=> !busy, "block did not return idle after the result")
	`CRV_ASSERT(a_load_idle, (start && !busy && !last) |=> (!busy && !done),
		"a transfer without last left the idle state")
	`CRV_ASSERT_ALWAYS(a_no_ovf_idle, (!arst_n) |-> !overflow, "overflow set during reset")

endmodule
